// File: rtl/cfs_pkg.sv
// Shared constants, types and the coefficient table of the spectrum smoother.
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

  localparam int TAPS            = 251;
  localparam int HALF_SPAN       = 125;
  localparam int COEF_HALF_COUNT = 126;
  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_BITS       = 18;
  localparam int POS_BITS        = 12;
  localparam int ADDR_BITS       = $clog2(TAPS);
  localparam int OWED_BITS       = $clog2(HALF_SPAN + 1);
  localparam int J_BITS          = $clog2(TAPS) + 2;
  localparam int CIDX_BITS       = $clog2(COEF_HALF_COUNT);
  localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS        = PROD_BITS + $clog2(TAPS);
  localparam int ROUND_SHIFT     = 20;
  localparam int DRAIN_CYCLES    = 2;

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } seq_state_e;

  // One tap command from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic                 clear;
    logic                 step;
    logic                 live;
    logic [CIDX_BITS-1:0] cidx;
  } tap_cmd_t;

  // Q0.20 coefficients of taps 0 to 125; the other half mirrors them.
  localparam logic signed [COEF_BITS-1:0] COEF_HALF [COEF_HALF_COUNT] = '{
    -18'sd162, -18'sd158, -18'sd155, -18'sd152, -18'sd149,
    -18'sd146, -18'sd144, -18'sd141, -18'sd139, -18'sd136,
    -18'sd133, -18'sd130, -18'sd127, -18'sd123, -18'sd118,
    -18'sd113, -18'sd107, -18'sd100, -18'sd92,  -18'sd83,
    -18'sd73,  -18'sd61,  -18'sd48,  -18'sd34,  -18'sd18,
    18'sd0,    18'sd20,   18'sd42,   18'sd66,   18'sd92,
    18'sd120,  18'sd152,  18'sd185,  18'sd222,  18'sd261,
    18'sd303,  18'sd348,  18'sd396,  18'sd447,  18'sd502,
    18'sd560,  18'sd622,  18'sd687,  18'sd755,  18'sd828,
    18'sd904,  18'sd983,  18'sd1067, 18'sd1154, 18'sd1245,
    18'sd1340, 18'sd1439, 18'sd1542, 18'sd1649, 18'sd1760,
    18'sd1874, 18'sd1993, 18'sd2115, 18'sd2241, 18'sd2370,
    18'sd2504, 18'sd2641, 18'sd2781, 18'sd2925, 18'sd3072,
    18'sd3222, 18'sd3376, 18'sd3532, 18'sd3692, 18'sd3854,
    18'sd4019, 18'sd4186, 18'sd4355, 18'sd4527, 18'sd4700,
    18'sd4875, 18'sd5052, 18'sd5230, 18'sd5410, 18'sd5590,
    18'sd5772, 18'sd5954, 18'sd6136, 18'sd6318, 18'sd6500,
    18'sd6682, 18'sd6864, 18'sd7045, 18'sd7224, 18'sd7403,
    18'sd7580, 18'sd7755, 18'sd7929, 18'sd8100, 18'sd8269,
    18'sd8435, 18'sd8599, 18'sd8759, 18'sd8916, 18'sd9070,
    18'sd9220, 18'sd9365, 18'sd9507, 18'sd9644, 18'sd9777,
    18'sd9905, 18'sd10028, 18'sd10146, 18'sd10258, 18'sd10365,
    18'sd10466, 18'sd10562, 18'sd10651, 18'sd10735, 18'sd10812,
    18'sd10883, 18'sd10948, 18'sd11006, 18'sd11057, 18'sd11102,
    18'sd11140, 18'sd11171, 18'sd11195, 18'sd11213, 18'sd11223,
    18'sd11227
  };

  function automatic logic signed [COEF_BITS-1:0] coef_of(input logic [CIDX_BITS-1:0] m);
    logic signed [COEF_BITS-1:0] c;
    if (m < CIDX_BITS'(COEF_HALF_COUNT)) begin
      c = COEF_HALF[m];
    end else begin
      c = COEF_HALF[COEF_HALF_COUNT-1];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfs_if.sv
// Valid/ready channel interfaces for the input samples and the filtered results.
`timescale 1ns / 1ps
`default_nettype none

interface cfs_in_if;
  logic                                       valid;
  logic                                       ready;
  cfs_pkg::func_e                             func;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0]     sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);
endinterface

interface cfs_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0]     filtered;
  logic        [cfs_pkg::POS_BITS-1:0]        position;
  logic                                       last;

  modport source (output valid, output filtered, output position, output last, input ready);
  modport sink   (input valid, input filtered, input position, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/centered_fir_spectrum_smoother.sv
// Top level of the centered 251-tap spectrum smoother: sequencer, window and MAC.
// Samples of one spectrum enter on in_i as push transfers (func 0), followed
// by flush transfers (func 1) that drain the outputs still owed at the end.
// Each output is the 251-tap symmetric low-pass filter centered on one sample,
// with samples outside the spectrum taken as zero. Results leave on out_o with
// their position in the spectrum; the final one carries last, after which the
// window, the owed count and the position start over for the next spectrum.
// The first 125 pushes of a spectrum only store; every later push and every
// flush that is owed an output produces exactly one result. A flush with
// nothing owed is dropped without a result.
// A storing push only writes the window and leaves the sequencer idle. For a
// producing item, one shared multiplier walks the 251 taps one per cycle
// through the window memory's read port, then a pipeline drain state and a
// rounding state follow before the result enters the output register.
// in_i.ready is high only while the sequencer idles, so no new item is taken while one is in work.
// If the receiver stalls, the result waits in the output register; the next
// item is still taken and computed, and its result waits in the accumulator
// until the output register frees up. Reset is asynchronous and active low;
// it empties the window, clears the owed count and position, and drops any
// result not yet transferred.
`timescale 1ns / 1ps
`default_nettype none

module centered_fir_spectrum_smoother (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfs_in_if.sink     in_i,
  cfs_out_if.source  out_o
);

  localparam int AB = cfs_pkg::ADDR_BITS;
  localparam int JB = cfs_pkg::J_BITS;

  cfs_pkg::seq_state_e state_q, state_d;

  logic [AB-1:0]                        wr_ptr_q;
  logic [AB-1:0]                        rd_ptr_q;
  logic [AB-1:0]                        cnt_q;
  logic signed [JB-1:0]                 j_q;
  logic [cfs_pkg::OWED_BITS-1:0]        owed_q;
  logic [cfs_pkg::POS_BITS-1:0]         pos_q;
  logic                                 last_q;

  logic                                 out_valid_q;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0] out_filtered_q;
  logic [cfs_pkg::POS_BITS-1:0]         out_position_q;
  logic                                 out_last_q;

  logic                                 accept;
  logic                                 is_push;
  logic                                 owed_full;
  logic                                 emits;
  logic                                 out_free;
  logic                                 deliver;
  logic                                 tap_last;
  cfs_pkg::tap_cmd_t                    cmd;
  logic signed [JB-1:0]                 j_mirror;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0] win_data;
  logic                                 win_valid;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0] mac_result;

  assign accept    = in_i.valid && in_i.ready;
  assign is_push   = (in_i.func == cfs_pkg::FUNC_PUSH);
  assign owed_full = (owed_q == cfs_pkg::OWED_BITS'(cfs_pkg::HALF_SPAN));
  // A push emits once the owed count is full; a flush emits while anything is owed.
  assign emits     = is_push ? owed_full : (owed_q != '0);
  assign out_free  = !out_valid_q || out_o.ready;
  assign deliver   = (state_q == cfs_pkg::ST_ROUND) && out_free;
  assign tap_last  = (cnt_q == AB'(cfs_pkg::TAPS - 1));
  assign j_mirror  = JB'(cfs_pkg::TAPS - 1) - j_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfs_pkg::ST_IDLE: begin
        if (accept && emits) begin
          state_d = cfs_pkg::ST_RUN;
        end
      end
      cfs_pkg::ST_RUN: begin
        if (tap_last) begin
          state_d = cfs_pkg::ST_DRAIN;
        end
      end
      cfs_pkg::ST_DRAIN: begin
        if (cnt_q == AB'(cfs_pkg::DRAIN_CYCLES - 1)) begin
          state_d = cfs_pkg::ST_ROUND;
        end
      end
      cfs_pkg::ST_ROUND: begin
        if (out_free) begin
          state_d = cfs_pkg::ST_IDLE;
        end
      end
      default: state_d = cfs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. Tap j of the filter meets window entry k; the walk
  // goes from the newest entry backward while j counts down, and taps that
  // fall outside the filter are marked dead so they add nothing.
  always_comb begin
    in_i.ready = (state_q == cfs_pkg::ST_IDLE);
    cmd.clear  = accept;
    cmd.step   = (state_q == cfs_pkg::ST_RUN);
    cmd.live   = (j_q >= 0) && (j_q < JB'(cfs_pkg::TAPS));
    if (j_q <= JB'(cfs_pkg::HALF_SPAN)) begin
      cmd.cidx = j_q[cfs_pkg::CIDX_BITS-1:0];
    end else begin
      cmd.cidx = j_mirror[cfs_pkg::CIDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window pointers, tap walk and spectrum bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      j_q      <= '0;
      owed_q   <= '0;
      pos_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      unique case (state_q)
        cfs_pkg::ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            if (is_push) begin
              wr_ptr_q <= (wr_ptr_q == AB'(cfs_pkg::TAPS - 1)) ? '0 : wr_ptr_q + AB'(1);
              rd_ptr_q <= wr_ptr_q;
              j_q      <= JB'(2 * cfs_pkg::HALF_SPAN);
              last_q   <= 1'b0;
              if (!owed_full) begin
                owed_q <= owed_q + cfs_pkg::OWED_BITS'(1);
              end
            end else if (owed_q != '0) begin
              // A flush reads the window as if zeros had been shifted in.
              rd_ptr_q <= (wr_ptr_q == '0) ? AB'(cfs_pkg::TAPS - 1) : wr_ptr_q - AB'(1);
              j_q      <= JB'(owed_q) + JB'(cfs_pkg::HALF_SPAN - 1);
              last_q   <= (owed_q == cfs_pkg::OWED_BITS'(1));
              owed_q   <= owed_q - cfs_pkg::OWED_BITS'(1);
            end
          end
        end
        cfs_pkg::ST_RUN: begin
          cnt_q    <= tap_last ? '0 : cnt_q + AB'(1);
          rd_ptr_q <= (rd_ptr_q == '0) ? AB'(cfs_pkg::TAPS - 1) : rd_ptr_q - AB'(1);
          j_q      <= j_q - JB'(1);
        end
        cfs_pkg::ST_DRAIN: begin
          cnt_q <= cnt_q + AB'(1);
        end
        cfs_pkg::ST_ROUND: begin
          if (out_free) begin
            if (last_q) begin
              pos_q    <= '0;
              owed_q   <= '0;
              wr_ptr_q <= '0;
            end else begin
              pos_q <= pos_q + cfs_pkg::POS_BITS'(1);
            end
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (deliver) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      out_filtered_q <= mac_result;
      out_position_q <= pos_q;
      out_last_q     <= last_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_filtered_q;
  assign out_o.position = out_position_q;
  assign out_o.last     = out_last_q;

  cfs_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (deliver && last_q),
    .wr_en_i    (accept && is_push),
    .wr_addr_i  (wr_ptr_q),
    .wr_data_i  (in_i.sample),
    .rd_en_i    (cmd.step),
    .rd_addr_i  (rd_ptr_q),
    .rd_data_o  (win_data),
    .rd_valid_o (win_valid)
  );

  cfs_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (win_data),
    .sample_ok_i (win_valid),
    .result_o    (mac_result)
  );

endmodule

`default_nettype wire

// File: rtl/cfs_window.sv
// Circular sample window memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cfs_window (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   clear_i,
  input  logic                                   wr_en_i,
  input  logic [cfs_pkg::ADDR_BITS-1:0]          wr_addr_i,
  input  logic signed [cfs_pkg::SAMPLE_BITS-1:0] wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [cfs_pkg::ADDR_BITS-1:0]          rd_addr_i,
  output logic signed [cfs_pkg::SAMPLE_BITS-1:0] rd_data_o,
  output logic                                   rd_valid_o
);

  logic signed [cfs_pkg::SAMPLE_BITS-1:0] mem_q [cfs_pkg::TAPS];
  logic [cfs_pkg::TAPS-1:0]               valid_q;
  logic signed [cfs_pkg::SAMPLE_BITS-1:0] rd_data_q;
  logic                                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written since the last clear or reset are flagged not valid on the read port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

`default_nettype wire

// File: rtl/cfs_mac.sv
// Shared pipelined multiply-accumulate unit with rounding and saturation to Q4.12.
`timescale 1ns / 1ps
`default_nettype none

module cfs_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cfs_pkg::tap_cmd_t                      cmd_i,
  input  logic signed [cfs_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   sample_ok_i,
  output logic signed [cfs_pkg::SAMPLE_BITS-1:0] result_o
);

  localparam int AW = cfs_pkg::ACC_BITS;
  localparam logic signed [AW-1:0] SAT_HI   = AW'(2 ** (cfs_pkg::SAMPLE_BITS - 1) - 1);
  localparam logic signed [AW-1:0] SAT_LO   = -SAT_HI - AW'(1);
  localparam logic signed [AW-1:0] ROUND_HF = AW'(2 ** (cfs_pkg::ROUND_SHIFT - 1));

  logic signed [cfs_pkg::COEF_BITS-1:0] coef_q;
  logic                                 live_q;
  logic                                 step0_q;
  logic signed [cfs_pkg::PROD_BITS-1:0] prod_q;
  logic                                 step1_q;
  logic signed [AW-1:0]                 acc_q;
  logic signed [AW-1:0]                 rsum;
  logic signed [AW-1:0]                 quot;

  // Stage 0 runs beside the window read: coefficient lookup.
  always_ff @(posedge clk_i) begin
    coef_q <= cfs_pkg::coef_of(cmd_i.cidx);
    live_q <= cmd_i.live;
  end

  // Stage 1: product, zero for taps outside the filter or unwritten entries.
  always_ff @(posedge clk_i) begin
    if (live_q && sample_ok_i) begin
      prod_q <= cfs_pkg::PROD_BITS'(sample_i) * cfs_pkg::PROD_BITS'(coef_q);
    end else begin
      prod_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step0_q <= 1'b0;
      step1_q <= 1'b0;
    end else begin
      step0_q <= cmd_i.step;
      step1_q <= step0_q;
    end
  end

  // Stage 2: accumulate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      acc_q <= '0;
    end else if (step1_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  // Round half up, floor to Q4.12, then saturate.
  always_comb begin
    rsum = acc_q + ROUND_HF;
    quot = rsum >>> cfs_pkg::ROUND_SHIFT;
    if (quot > SAT_HI) begin
      result_o = SAT_HI[cfs_pkg::SAMPLE_BITS-1:0];
    end else if (quot < SAT_LO) begin
      result_o = SAT_LO[cfs_pkg::SAMPLE_BITS-1:0];
    end else begin
      result_o = quot[cfs_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfs_checker.sv
// Port-level checker for the spectrum smoother and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cfs_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [cfs_pkg::SAMPLE_BITS-1:0] filtered_i,
  input logic [cfs_pkg::POS_BITS-1:0]           position_i,
  input logic                                   last_i
);

  logic [cfs_pkg::POS_BITS-1:0] exp_pos_q, exp_pos_d;

  // Positions run consecutively within a spectrum and restart after last.
  always_comb begin
    exp_pos_d = exp_pos_q;
    if (out_valid_i && out_ready_i) begin
      exp_pos_d = last_i ? '0 : position_i + cfs_pkg::POS_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else begin
      exp_pos_q <= exp_pos_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while the receiver stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(filtered_i) && $stable(position_i) && $stable(last_i))
    else $error("stalled result changed");

  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> position_i == exp_pos_q)
    else $error("result position out of sequence");

  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a computation pass");

endmodule

bind centered_fir_spectrum_smoother cfs_checker u_cfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .filtered_i  (out_o.filtered),
  .position_i  (out_o.position),
  .last_i      (out_o.last)
);

`default_nettype wire
